/* rtl/ir_drop_pulse_counter_macros.svh */
// Assertion macros for the drop pulse counter.
// Used by the modules that carry concurrent checks; needs nothing else.
`ifndef IR_DROP_PULSE_COUNTER_MACROS_SVH
`define IR_DROP_PULSE_COUNTER_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define IDPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idpc: same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define IDPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idpc: next-cycle check failed");

`endif

/* rtl/idpc_pkg.sv */
// Shared types and constants for the drop pulse counter.
// No dependencies; imported by every module of the block.
package idpc_pkg;

   localparam int COUNT_BITS = 8;
   localparam int FIELD_COUNT_W = 8;
   localparam int TIME_W = 32;
   localparam int LEVEL_W = 10;
   localparam int CFG_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int STEP_W = $clog2(TIME_W);

   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_ABORT = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARM_DELAY = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN = 2'd3;

   localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 10'd512;
   localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd5;
   localparam logic [CFG_W-1:0] ARM_DELAY_RST = 16'd300;
   localparam logic [CFG_W-1:0] COOLDOWN_RST = 16'd100;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_FINISH
   } idpc_state_type;

   typedef struct packed {
      logic capture;
      logic start_div;
      logic commit;
   } idpc_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
      logic div_done;
   } idpc_sts_type;

endpackage

/* rtl/idpc_divider.sv */
// Restoring divider, one quotient bit per cycle, for the mean interval.
// Depends on idpc_pkg.
module idpc_divider import idpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_W-1:0]     dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   output logic                  done,
   output logic [TIME_W-1:0]     quotient
);

   logic                  busy_ff, busy_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [TIME_W-1:0]     quot_ff, quot_in;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, quot_ff[TIME_W-1]};
   assign fits = trial >= {1'b0, div_ff};
   assign done = busy_ff && (step_ff == STEP_W'(TIME_W - 1));
   assign quotient = quot_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in = '0;
         div_in = divisor;
         quot_in = dividend;
      end else if (busy_ff) begin
         // shift one dividend bit into the partial remainder
         rem_in = fits ? COUNT_BITS'(trial - {1'b0, div_ff}) : trial[COUNT_BITS-1:0];
         quot_in = {quot_ff[TIME_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      div_ff <= div_in;
      quot_ff <= quot_in;
   end

endmodule

/* rtl/idpc_datapath.sv */
// Datapath: configuration, session state, request latch, result register.
// Depends on idpc_pkg and idpc_divider.
module idpc_datapath import idpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  idpc_cmd_type             cmd,
   output idpc_sts_type             sts,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   input  logic [1:0]               req_opcode,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic [LEVEL_W-1:0]       req_sensor_level,
   input  logic [FIELD_COUNT_W-1:0] req_start_count,
   input  logic                     req_timing_on,
   input  logic                     req_limit_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_session_active,
   output logic [FIELD_COUNT_W-1:0] rsp_drop_count,
   output logic [FIELD_COUNT_W-1:0] rsp_remaining,
   output logic                     rsp_counted_now,
   output logic                     rsp_finished,
   output logic [TIME_W-1:0]        rsp_average_ms,
   output logic                     rsp_start_refused
);

   // configuration
   logic [LEVEL_W-1:0] threshold_ff;
   logic [CFG_W-1:0]   period_ff, arm_ff, cooldown_ff;

   // latched request
   logic [1:0]            op_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [COUNT_BITS-1:0] want_ff;
   logic                  timing_ff, limit_ff;

   // session state
   logic                  running_ff, running_in;
   logic                  was_above_ff, was_above_in;
   logic                  timing_act_ff, timing_act_in;
   logic [COUNT_BITS-1:0] target_ff, target_in;
   logic [COUNT_BITS-1:0] counted_ff, counted_in;
   logic [COUNT_BITS-1:0] itotal_ff, itotal_in;
   logic [TIME_W-1:0]     lockout_ff, lockout_in;
   logic [TIME_W-1:0]     sess_start_ff, sess_start_in;
   logic [TIME_W-1:0]     last_sample_ff, last_sample_in;
   logic [TIME_W-1:0]     last_count_ff, last_count_in;
   logic [TIME_W-1:0]     isum_ff, isum_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     active_ff, counted_now_ff, finished_ff, refused_ff;
   logic [FIELD_COUNT_W-1:0] drop_ff, remaining_ff;
   logic [TIME_W-1:0]        average_ff;

   // evaluation of the latched request
   logic                  cnt_now, fin, refused, need_div;
   logic [COUNT_BITS-1:0] shown, remain;
   logic                  sample_ok, above, armed, unlocked;
   logic [TIME_W-1:0]     since_lock;
   logic [COUNT_BITS-1:0] counted_inc;
   logic                  div_done;
   logic [TIME_W-1:0]     quotient;

   assign sample_ok = (op_ff == OP_SAMPLE) && running_ff &&
                      ((now_ff - last_sample_ff) >= TIME_W'(period_ff));
   assign above = level_ff > threshold_ff;
   assign armed = (now_ff - sess_start_ff) > TIME_W'(arm_ff);
   assign since_lock = now_ff - lockout_ff;
   assign unlocked = (counted_ff == '0) || !since_lock[TIME_W-1];
   assign counted_inc = counted_ff + 1'b1;

   always_comb begin
      running_in = running_ff;
      was_above_in = was_above_ff;
      timing_act_in = timing_act_ff;
      target_in = target_ff;
      counted_in = counted_ff;
      itotal_in = itotal_ff;
      lockout_in = lockout_ff;
      sess_start_in = sess_start_ff;
      last_sample_in = last_sample_ff;
      last_count_in = last_count_ff;
      isum_in = isum_ff;
      cnt_now = 1'b0;
      fin = 1'b0;
      refused = 1'b0;
      need_div = 1'b0;
      shown = '0;
      unique case (op_ff)
         OP_START: begin
            if (want_ff == '0 || running_ff) begin
               refused = 1'b1;
            end else begin
               if (timing_ff) begin
                  last_count_in = '0;
                  isum_in = '0;
                  itotal_in = '0;
               end
               if (limit_ff) begin
                  // switch pressed: statistics may clear, session stays off
                  timing_act_in = 1'b0;
                  refused = 1'b1;
               end else begin
                  timing_act_in = timing_ff;
                  target_in = want_ff;
                  counted_in = '0;
                  lockout_in = '0;
                  was_above_in = 1'b0;
                  sess_start_in = now_ff;
                  last_sample_in = '0;
                  running_in = 1'b1;
               end
            end
         end
         OP_ABORT: begin
            running_in = 1'b0;
            target_in = '0;
            counted_in = '0;
            timing_act_in = 1'b0;
         end
         default: begin
            if (sample_ok) begin
               last_sample_in = now_ff;
               was_above_in = above;
               if (armed && above && !was_above_ff && unlocked) begin
                  cnt_now = 1'b1;
                  counted_in = counted_inc;
                  if (timing_act_ff) begin
                     if (counted_ff != '0) begin
                        isum_in = isum_ff + (now_ff - last_count_ff);
                        itotal_in = itotal_ff + 1'b1;
                     end
                     last_count_in = now_ff;
                  end
                  lockout_in = now_ff + TIME_W'(cooldown_ff);
                  if (counted_inc >= target_ff) begin
                     fin = 1'b1;
                     need_div = timing_act_ff && (itotal_in != '0);
                     running_in = 1'b0;
                     target_in = '0;
                     counted_in = '0;
                     timing_act_in = 1'b0;
                  end
               end
            end
         end
      endcase
      shown = fin ? counted_inc : counted_in;
      remain = (target_in > counted_in) ? target_in - counted_in : '0;
   end

   idpc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (isum_in),
      .divisor  (itotal_in),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid_in = cmd.commit | (rsp_valid_ff & rsp_stall);

   assign sts.need_div = need_div;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.div_done = div_done;

   // configuration writes land at once
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= LEVEL_THRESHOLD_RST;
         period_ff <= SAMPLE_PERIOD_RST;
         arm_ff <= ARM_DELAY_RST;
         cooldown_ff <= COOLDOWN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LEVEL_THRESHOLD: threshold_ff <= csr_data[LEVEL_W-1:0];
            CSR_SAMPLE_PERIOD:   period_ff <= csr_data;
            CSR_ARM_DELAY:       arm_ff <= csr_data;
            CSR_COOLDOWN:        cooldown_ff <= csr_data;
            default:             threshold_ff <= threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_opcode;
         now_ff <= req_now_ms;
         level_ff <= req_sensor_level;
         want_ff <= COUNT_BITS'(req_start_count);
         timing_ff <= req_timing_on;
         limit_ff <= req_limit_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         was_above_ff <= 1'b0;
         timing_act_ff <= 1'b0;
         target_ff <= '0;
         counted_ff <= '0;
         itotal_ff <= '0;
         lockout_ff <= '0;
         sess_start_ff <= '0;
         last_sample_ff <= '0;
         last_count_ff <= '0;
         isum_ff <= '0;
      end else if (cmd.commit) begin
         running_ff <= running_in;
         was_above_ff <= was_above_in;
         timing_act_ff <= timing_act_in;
         target_ff <= target_in;
         counted_ff <= counted_in;
         itotal_ff <= itotal_in;
         lockout_ff <= lockout_in;
         sess_start_ff <= sess_start_in;
         last_sample_ff <= last_sample_in;
         last_count_ff <= last_count_in;
         isum_ff <= isum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.commit) begin
         active_ff <= running_in;
         drop_ff <= FIELD_COUNT_W'(shown);
         remaining_ff <= FIELD_COUNT_W'(remain);
         counted_now_ff <= cnt_now;
         finished_ff <= fin;
         average_ff <= need_div ? quotient : '0;
         refused_ff <= refused;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_session_active = active_ff;
   assign rsp_drop_count = drop_ff;
   assign rsp_remaining = remaining_ff;
   assign rsp_counted_now = counted_now_ff;
   assign rsp_finished = finished_ff;
   assign rsp_average_ms = average_ff;
   assign rsp_start_refused = refused_ff;

endmodule

/* rtl/idpc_ctrl.sv */
// Controller state machine: request intake, divide wait, result commit.
// Depends on idpc_pkg and the assertion macros header.
`include "ir_drop_pulse_counter_macros.svh"

module idpc_ctrl import idpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  idpc_sts_type sts,
   output idpc_cmd_type cmd
);

   idpc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.need_div) begin
               state_in = ST_DIVIDE;
            end else if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EVAL: begin
            cmd.start_div = sts.need_div;
            cmd.commit = !sts.need_div && sts.out_free;
         end
         ST_DIVIDE: begin
            cmd = '0;
         end
         ST_FINISH: begin
            cmd.commit = sts.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `IDPC_ASSERT_NOW(a_commit_needs_room, clock, reset, cmd.commit, sts.out_free)
   `IDPC_ASSERT_NOW(a_finish_has_quotient, clock, reset, state_ff == ST_FINISH, sts.need_div)
   `IDPC_ASSERT_NOW(a_div_done_in_wait, clock, reset, sts.div_done, state_ff == ST_DIVIDE)
   `IDPC_ASSERT_NEXT(a_commit_frees_intake, clock, reset, cmd.commit, state_ff == ST_IDLE)

endmodule

/* rtl/ir_drop_pulse_counter.sv */
// Top level of the drop pulse counter: controller plus datapath.
// Depends on idpc_pkg, idpc_ctrl and idpc_datapath.
//
// Use: requests (sample, start, abort) enter on req_* under valid/stall; every
// request yields exactly one result on rsp_*, in order. Configuration is a
// plain write port (csr_write, csr_index, csr_data), taken in any cycle;
// write it only while no request is in flight.
// Timing: a request is taken in the idle state and evaluated in the next
// cycle; its result is registered when it commits, which holds while the
// previous result is still waiting to be taken.
// A sample that completes a timed session with at least one interval divides
// the interval sum by the interval count in a restoring divider, one quotient
// bit per cycle; that request passes intake, evaluate, divide and commit.
// The result register decouples the two sides: a new request is taken while
// the previous result waits; evaluation then holds until the result is taken.
// Reset is synchronous and active high: it clears the session, restores the
// register defaults (threshold 512, period 5, arm delay 300, cooldown 100)
// and drops rsp_valid.
module ir_drop_pulse_counter import idpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]         csr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [TIME_W-1:0]        req_now_ms,
   input  logic [LEVEL_W-1:0]       req_sensor_level,
   input  logic [FIELD_COUNT_W-1:0] req_start_count,
   input  logic                     req_timing_on,
   input  logic                     req_limit_pressed,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_session_active,
   output logic [FIELD_COUNT_W-1:0] rsp_drop_count,
   output logic [FIELD_COUNT_W-1:0] rsp_remaining,
   output logic                     rsp_counted_now,
   output logic                     rsp_finished,
   output logic [TIME_W-1:0]        rsp_average_ms,
   output logic                     rsp_start_refused
);

   idpc_cmd_type cmd;
   idpc_sts_type sts;

   // sequencing: intake, evaluate, optional divide, commit
   idpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // session state, configuration, divider and the result register
   idpc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_opcode         (req_opcode),
      .req_now_ms         (req_now_ms),
      .req_sensor_level   (req_sensor_level),
      .req_start_count    (req_start_count),
      .req_timing_on      (req_timing_on),
      .req_limit_pressed  (req_limit_pressed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_session_active (rsp_session_active),
      .rsp_drop_count     (rsp_drop_count),
      .rsp_remaining      (rsp_remaining),
      .rsp_counted_now    (rsp_counted_now),
      .rsp_finished       (rsp_finished),
      .rsp_average_ms     (rsp_average_ms),
      .rsp_start_refused  (rsp_start_refused)
   );

endmodule
